// ----- rtl/vqncs_pkg.sv -----
// ---------------------------------------------------------------------------
// vqncs_pkg: shared types and constants for the nearest codeword search
// Holds the sequencer states, the compare-stage control group, the field
// widths of the request and result, and the channel difference helper.
// ---------------------------------------------------------------------------
package vqncs_pkg;

  localparam int CHAN_W    = 8;
  localparam int WORD_W    = 3 * CHAN_W;
  localparam int DIST_W    = 10;
  localparam int SQ_W      = 18;
  localparam int OUT_IDX_W = 8;
  localparam int ENTRY_W   = 8;
  localparam int CFG_W     = 4;
  localparam int CFG_RESET = 8;
  localparam int DIST_MAX  = 765;

  // request kinds carried in tuser
  localparam logic MODE_WRITE    = 1'b0;
  localparam logic MODE_QUANTIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SQ,
    ST_DONE
  } state_t;

  // control for the compare stage, aligned with registered table data
  typedef struct packed {
    logic valid;
    logic first;
  } cmp_ctrl_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- rtl/vqncs_l1_cmp.sv -----
// ---------------------------------------------------------------------------
// vqncs_l1_cmp: L1 distance and running minimum
// Computes the L1 distance of one table word against the pixel each cycle
// the compare stage is valid and keeps the best index, distance and word.
// Ties keep the earlier (lower) index.
// ---------------------------------------------------------------------------
module vqncs_l1_cmp #(
  parameter int IDX_W = 8
) (
  input  logic                            clk,
  input  logic [vqncs_pkg::WORD_W-1:0]    pixel,
  input  logic [vqncs_pkg::WORD_W-1:0]    word,
  input  vqncs_pkg::cmp_ctrl_t            ctrl,
  input  logic [IDX_W-1:0]                idx,
  output logic [vqncs_pkg::DIST_W-1:0]    best_dist,
  output logic [IDX_W-1:0]                best_idx,
  output logic [vqncs_pkg::WORD_W-1:0]    best_word
);

  localparam int CW = vqncs_pkg::CHAN_W;

  logic [CW-1:0]                  d0, d1, d2;
  logic [vqncs_pkg::DIST_W-1:0]   l1_sum;

  // sum the three channel differences
  always_comb begin
    d0     = vqncs_pkg::abs_diff(pixel[CW-1:0],      word[CW-1:0]);
    d1     = vqncs_pkg::abs_diff(pixel[2*CW-1:CW],   word[2*CW-1:CW]);
    d2     = vqncs_pkg::abs_diff(pixel[3*CW-1:2*CW], word[3*CW-1:2*CW]);
    l1_sum = vqncs_pkg::DIST_W'(d0) + vqncs_pkg::DIST_W'(d1) + vqncs_pkg::DIST_W'(d2);
  end

  // hold the best candidate; the first entry always loads
  always_ff @(posedge clk) begin
    if (ctrl.valid && (ctrl.first || l1_sum < best_dist)) begin
      best_dist <= l1_sum;
      best_idx  <= idx;
      best_word <= word;
    end
  end

endmodule

// ----- rtl/vq_nearest_codeword_search_unit.sv -----
// ---------------------------------------------------------------------------
// vq_nearest_codeword_search_unit: L1 nearest codeword vector quantizer
// Write requests load the codeword table; quantize requests scan the active
// entries one per cycle and return index, codeword, L1 distance and squared
// error.
//
//  channel  | direction | handshake                  | content
//  s_axis   | in        | tvalid/tready              | tuser mode, tdata entry+pixel
//  m_axis   | out       | tvalid/tready              | tdata index, word, dist, sq
//  cfg      | in        | cfg_we                     | codebook_bits
//
// A quantize request makes one table read per active entry on the single
// read port, passes a drain state, squares the three channel differences on
// the shared 8x8 squarer, and then loads the output.
// Reset (synchronous) returns the sequencer to idle, empties the output and
// sets codebook_bits to 8; the table is not cleared. A result waiting on
// m_axis does not block the next request; only the final load waits on it.
// ---------------------------------------------------------------------------
module vq_nearest_codeword_search_unit #(
  parameter int MAX_CODE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] entry_index, [15:8] chan0, [23:16] chan1, [31:24] chan2
  input  logic [31:0] s_axis_tdata,
  // [0] mode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] code_index, [15:8] out_chan0, [23:16] out_chan1, [31:24] out_chan2,
  // [41:32] abs_distance, [59:42] sq_error, [63:60] zero
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int AW    = MAX_CODE_BITS;
  localparam int DEPTH = 1 << AW;
  localparam int CNT_W = AW + 1;
  localparam int CW    = vqncs_pkg::CHAN_W;
  localparam int WW    = vqncs_pkg::WORD_W;

  vqncs_pkg::state_t state, state_next;

  logic [vqncs_pkg::CFG_W-1:0]   code_bits;
  logic [vqncs_pkg::CFG_W-1:0]   bits_sat;
  logic [AW-1:0]                 last_req;
  logic [AW-1:0]                 last_idx;
  logic [AW-1:0]                 scan_addr;
  logic [WW-1:0]                 pixel;
  logic [WW-1:0]                 table_mem [DEPTH];
  logic [WW-1:0]                 rd_data;
  logic [AW-1:0]                 rd_idx;
  logic                          rd_valid;
  vqncs_pkg::cmp_ctrl_t          cmp_ctrl;
  logic [vqncs_pkg::DIST_W-1:0]  best_dist;
  logic [AW-1:0]                 best_idx;
  logic [WW-1:0]                 best_word;
  logic [1:0]                    sq_step;
  logic [CW-1:0]                 sq_diff;
  logic [2*CW-1:0]               sq_prod;
  logic [vqncs_pkg::SQ_W-1:0]    sq_acc;
  logic                          s_accept;
  logic                          is_write;
  logic                          out_load;
  logic [63:0]                   out_data;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign is_write = (s_axis_tuser == vqncs_pkg::MODE_WRITE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits <= vqncs_pkg::CFG_W'(vqncs_pkg::CFG_RESET);
    end else if (cfg_we) begin
      code_bits <= cfg_wdata;
    end
  end

  // saturate the active size and form the last entry index
  always_comb begin
    bits_sat = (code_bits > vqncs_pkg::CFG_W'(MAX_CODE_BITS)) ?
               vqncs_pkg::CFG_W'(MAX_CODE_BITS) : code_bits;
    last_req = AW'((CNT_W'(1) << bits_sat) - CNT_W'(1));
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vqncs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      vqncs_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && !is_write) begin
          state_next = vqncs_pkg::ST_SCAN;
        end
      end
      vqncs_pkg::ST_SCAN: begin
        if (scan_addr == last_idx) begin
          state_next = vqncs_pkg::ST_DRAIN;
        end
      end
      vqncs_pkg::ST_DRAIN: begin
        state_next = vqncs_pkg::ST_SQ;
      end
      vqncs_pkg::ST_SQ: begin
        if (sq_step == 2'd2) begin
          state_next = vqncs_pkg::ST_DONE;
        end
      end
      vqncs_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = vqncs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vqncs_pkg::ST_IDLE;
      end
    endcase
  end

  // capture the pixel and the scan bound, advance the scan address
  always_ff @(posedge clk) begin
    if (s_accept && !is_write) begin
      pixel     <= s_axis_tdata[31:8];
      last_idx  <= last_req;
      scan_addr <= '0;
    end else if (state == vqncs_pkg::ST_SCAN) begin
      scan_addr <= scan_addr + AW'(1);
    end
  end

  // codeword table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (s_accept && is_write) begin
      table_mem[AW'(s_axis_tdata[7:0])] <= s_axis_tdata[31:8];
    end
    rd_data <= table_mem[scan_addr];
  end

  // align index and valid with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == vqncs_pkg::ST_SCAN);
    end
    rd_idx <= scan_addr;
  end

  always_comb begin
    cmp_ctrl.valid = rd_valid;
    cmp_ctrl.first = (rd_idx == '0);
  end

  vqncs_l1_cmp #(
    .IDX_W (AW)
  ) u_l1_cmp (
    .clk       (clk),
    .pixel     (pixel),
    .word      (rd_data),
    .ctrl      (cmp_ctrl),
    .idx       (rd_idx),
    .best_dist (best_dist),
    .best_idx  (best_idx),
    .best_word (best_word)
  );

  // pick one channel difference for the shared squarer
  always_comb begin
    case (sq_step)
      2'd0:    sq_diff = vqncs_pkg::abs_diff(pixel[CW-1:0],      best_word[CW-1:0]);
      2'd1:    sq_diff = vqncs_pkg::abs_diff(pixel[2*CW-1:CW],   best_word[2*CW-1:CW]);
      2'd2:    sq_diff = vqncs_pkg::abs_diff(pixel[3*CW-1:2*CW], best_word[3*CW-1:2*CW]);
      default: sq_diff = '0;
    endcase
    sq_prod = sq_diff * sq_diff;
  end

  // accumulate squared error, one channel per cycle
  always_ff @(posedge clk) begin
    if (state == vqncs_pkg::ST_DRAIN) begin
      sq_step <= 2'd0;
      sq_acc  <= '0;
    end else if (state == vqncs_pkg::ST_SQ) begin
      sq_step <= sq_step + 2'd1;
      sq_acc  <= sq_acc + vqncs_pkg::SQ_W'(sq_prod);
    end
  end

  // result packing
  always_comb begin
    out_data        = '0;
    out_data[7:0]   = vqncs_pkg::OUT_IDX_W'(best_idx);
    out_data[31:8]  = best_word;
    out_data[41:32] = best_dist;
    out_data[59:42] = sq_acc;
  end

  // output register: load on completion, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_axis_tdata <= out_data;
    end
  end

  // scan never runs past the captured bound
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == vqncs_pkg::ST_SCAN |-> scan_addr <= last_idx)
    else $error("scan address beyond last active entry");

  // all compares are finished before the squared error starts
  a_sq_after_cmp: assert property (@(posedge clk) disable iff (rst)
    state == vqncs_pkg::ST_SQ |-> !rd_valid)
    else $error("compare still pending during squared error");

  // a new result only appears from the completion state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == vqncs_pkg::ST_DONE)
    else $error("result raised outside completion");

  // reported distance stays in range
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[41:32] <= vqncs_pkg::DIST_W'(vqncs_pkg::DIST_MAX))
    else $error("L1 distance out of range");

endmodule

// ----- tb/sv/vqncs_match_monitor.sv -----
// ---------------------------------------------------------------------------
// vqncs_match_monitor: result predictor and scoreboard for the codeword search
// Watches the request, result and configuration channels, keeps its own copy
// of the codeword table and the size register, works out the nearest codeword
// for each accepted quantize request, and compares every accepted result
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module vqncs_match_monitor #(
  parameter int MAX_CODE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [7:0] entry_index, [15:8] chan0, [23:16] chan1, [31:24] chan2
  input  logic [31:0] s_axis_tdata,
  // [0] mode
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] code_index, [15:8] out_chan0, [23:16] out_chan1, [31:24] out_chan2,
  // [41:32] abs_distance, [59:42] sq_error
  input  logic [63:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output int          fail_count
);

  // result layout, lowest field last so it lines up with m_axis_tdata[59:0]
  typedef struct packed {
    logic [vqncs_pkg::SQ_W-1:0]      sq_error;
    logic [vqncs_pkg::DIST_W-1:0]    abs_distance;
    logic [vqncs_pkg::CHAN_W-1:0]    chan2;
    logic [vqncs_pkg::CHAN_W-1:0]    chan1;
    logic [vqncs_pkg::CHAN_W-1:0]    chan0;
    logic [vqncs_pkg::OUT_IDX_W-1:0] code_index;
  } match_t;

  logic [vqncs_pkg::WORD_W-1:0] codeword_mem [1 << MAX_CODE_BITS];
  logic [vqncs_pkg::CFG_W-1:0]  size_bits;
  match_t                       nearest_q [$];
  int                           mismatch_cnt;
  int                           open_cnt;

  assign fail_count = mismatch_cnt + open_cnt;

  function automatic int chan_gap(input logic [vqncs_pkg::CHAN_W-1:0] a,
                                  input logic [vqncs_pkg::CHAN_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // scan the active entries; strict compare keeps the lowest index on ties
  function automatic match_t find_nearest(input logic [vqncs_pkg::CHAN_W-1:0] p0,
                                          input logic [vqncs_pkg::CHAN_W-1:0] p1,
                                          input logic [vqncs_pkg::CHAN_W-1:0] p2);
    int span;
    int best;
    int best_d;
    int d;
    int e0;
    int e1;
    int e2;
    logic [vqncs_pkg::WORD_W-1:0] w;
    match_t m;
    span   = 1 << ((int'(size_bits) > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(size_bits));
    best   = 0;
    best_d = vqncs_pkg::DIST_MAX + 1;
    for (int i = 0; i < span; i++) begin
      w = codeword_mem[i];
      d = chan_gap(p0, w[7:0]) + chan_gap(p1, w[15:8]) + chan_gap(p2, w[23:16]);
      if (d < best_d) begin
        best_d = d;
        best   = i;
      end
    end
    w  = codeword_mem[best];
    e0 = chan_gap(p0, w[7:0]);
    e1 = chan_gap(p1, w[15:8]);
    e2 = chan_gap(p2, w[23:16]);
    m.code_index   = best[vqncs_pkg::OUT_IDX_W-1:0];
    m.chan0        = w[7:0];
    m.chan1        = w[15:8];
    m.chan2        = w[23:16];
    m.abs_distance = best_d[vqncs_pkg::DIST_W-1:0];
    m.sq_error     = vqncs_pkg::SQ_W'(e0 * e0 + e1 * e1 + e2 * e2);
    return m;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] want_v,
                                    input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : track_requests
    match_t got;
    match_t want;
    match_t pred;
    if (rst) begin
      size_bits    = vqncs_pkg::CFG_W'(vqncs_pkg::CFG_RESET);
      mismatch_cnt = 0;
      open_cnt     = 0;
      nearest_q.delete();
    end else begin
      if (cfg_we) begin
        size_bits = cfg_wdata;
      end

      // retire results before taking new requests from the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[59:0];
        if (nearest_q.size() == 0) begin
          $error("result with no pending search: code_index %0d abs_distance %0d",
                 got.code_index, got.abs_distance);
          mismatch_cnt++;
        end else begin
          want = nearest_q.pop_front();
          mismatch_cnt += field_diff("code_index", 32'(want.code_index),
                                     32'(got.code_index));
          mismatch_cnt += field_diff("out_chan0", 32'(want.chan0), 32'(got.chan0));
          mismatch_cnt += field_diff("out_chan1", 32'(want.chan1), 32'(got.chan1));
          mismatch_cnt += field_diff("out_chan2", 32'(want.chan2), 32'(got.chan2));
          mismatch_cnt += field_diff("abs_distance", 32'(want.abs_distance),
                                     32'(got.abs_distance));
          mismatch_cnt += field_diff("sq_error", 32'(want.sq_error), 32'(got.sq_error));
        end
      end

      // store a codeword, or queue the predicted match for a pixel
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == vqncs_pkg::MODE_WRITE) begin
          codeword_mem[s_axis_tdata[7:0]] = s_axis_tdata[31:8];
        end else begin
          pred = find_nearest(s_axis_tdata[15:8], s_axis_tdata[23:16],
                              s_axis_tdata[31:24]);
          nearest_q.insert(nearest_q.size(), pred);
        end
      end
      open_cnt = nearest_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_vq_nearest_codeword_search_unit.sv -----
// ---------------------------------------------------------------------------
// tb_vq_nearest_codeword_search_unit: stimulus and verdict for the searcher
// Loads the codeword table, sweeps the codebook size through small, full and
// oversized settings, and sends directed then random pixels with random gaps
// and output stalls. Prediction and comparison live in vqncs_match_monitor.
// ---------------------------------------------------------------------------
module tb_vq_nearest_codeword_search_unit;

  localparam int RUN_LIMIT     = 3_000_000;
  // longest search scans all 2^8 entries; give a write or a search time to drain
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 1500;
  localparam int NUM_PHASES    = 13;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  int          fail_count;

  int          cycle_cnt = 0;
  int          results_seen;
  int          quant_sent;
  int          write_sent;
  int          active_count;
  bit          sender_quiet;
  bit          written_map [256];
  logic [23:0] entry_shadow [256];

  int phase_bits [NUM_PHASES] = '{2, 3, 1, 4, 5, 0, 6, 8, 15, 7, 9, 3, 4};
  int phase_len  [NUM_PHASES] = '{150, 200, 100, 250, 200, 60, 150, 90, 50, 100, 40, 150, 200};

  vq_nearest_codeword_search_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  vqncs_match_monitor i_match_mon (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // count accepted results
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
    end
  end

  function automatic int sender_gap();
    int r;
    if (sender_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic int recv_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 20);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  function automatic logic [7:0] rail();
    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
  endfunction

  function automatic logic [7:0] cluster_chan();
    return 8'd96 + 8'($urandom_range(0, 7));
  endfunction

  // mix of spread, clustered, duplicated and extreme codewords to force ties
  function automatic logic [23:0] pick_codeword();
    int r;
    int idx;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, 255);
    if (r < 40) return 24'($urandom());
    if (r < 70) return {cluster_chan(), cluster_chan(), cluster_chan()};
    if (r < 85 && written_map[idx]) return entry_shadow[idx];
    return {rail(), rail(), rail()};
  endfunction

  // pixels on, near, or between the active codewords, plus open-range noise
  function automatic logic [23:0] pick_pixel();
    int r;
    logic [23:0] w;
    r = $urandom_range(0, 99);
    w = entry_shadow[$urandom_range(0, active_count - 1)];
    if (r < 20) return w;
    if (r < 45) return {nudge(w[23:16]), nudge(w[15:8]), nudge(w[7:0])};
    if (r < 60) return {cluster_chan(), cluster_chan(), cluster_chan()};
    if (r < 70) return {rail(), rail(), rail()};
    return 24'($urandom());
  endfunction

  // offer one request after a random gap and hold it until accepted
  task automatic send_req(input logic mode, input logic [7:0] idx, input logic [7:0] c0,
                          input logic [7:0] c1, input logic [7:0] c2);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {c2, c1, c0, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (mode == vqncs_pkg::MODE_WRITE) begin
      written_map[idx]  = 1'b1;
      entry_shadow[idx] = {c2, c1, c0};
      write_sent++;
    end else begin
      quant_sent++;
    end
  endtask

  task automatic quantize(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
    send_req(vqncs_pkg::MODE_QUANTIZE, 8'($urandom_range(0, 255)), c0, c1, c2);
  endtask

  // drain all searches, then write the size register while the block is idle
  task automatic program_size(input logic [3:0] bits);
    s_axis_tvalid <= 1'b0;
    while (results_seen != quant_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= bits;
    @(posedge clk);
    cfg_we    <= 1'b0;
    active_count = 1 << ((bits > 4'd8) ? 8 : int'(bits));
  endtask

  // write every searchable entry that has never been loaded
  task automatic fill_active();
    logic [23:0] w;
    for (int i = 0; i < active_count; i++) begin
      if (!written_map[i]) begin
        w = pick_codeword();
        send_req(vqncs_pkg::MODE_WRITE, 8'(i), w[7:0], w[15:8], w[23:16]);
      end
    end
  endtask

  task automatic run_phase(input int bits, input int n);
    logic [23:0] w;
    logic [7:0]  idx;
    sender_quiet = ($urandom_range(0, 3) == 0);
    program_size(4'(bits));
    fill_active();
    repeat (n) begin
      if ($urandom_range(0, 99) < 55) begin
        w = pick_pixel();
        quantize(w[7:0], w[15:8], w[23:16]);
      end else begin
        idx = $urandom_range(0, 1) ? 8'($urandom_range(0, active_count - 1))
                                   : 8'($urandom_range(0, 255));
        w = pick_codeword();
        send_req(vqncs_pkg::MODE_WRITE, idx, w[7:0], w[15:8], w[23:16]);
      end
    end
  endtask

  // output side: random stalls, ready stretches, and one long hold-off
  initial begin : drive_ready
    int stall;
    int run;
    bit held;
    m_axis_tready = 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        stall = recv_stall();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = vqncs_pkg::MODE_WRITE;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    quant_sent    = 0;
    write_sent    = 0;
    active_count  = 1;
    sender_quiet  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single entry: distance extremes and the ignored index field
    program_size(4'd0);
    send_req(vqncs_pkg::MODE_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
    quantize(8'hFF, 8'hFF, 8'hFF);
    quantize(8'h00, 8'h00, 8'h00);
    send_req(vqncs_pkg::MODE_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    quantize(8'h00, 8'h00, 8'h00);
    quantize(8'h80, 8'h7F, 8'h01);
    send_req(vqncs_pkg::MODE_WRITE, 8'd255, 8'h12, 8'h34, 8'h56);
    send_req(vqncs_pkg::MODE_QUANTIZE, 8'hFF, 8'h55, 8'hAA, 8'h55);

    // two entries: tie goes low, distance one must not stop the scan
    program_size(4'd1);
    send_req(vqncs_pkg::MODE_WRITE, 8'd1, 8'hFF, 8'hFF, 8'hFF);
    quantize(8'h10, 8'h20, 8'h30);
    send_req(vqncs_pkg::MODE_WRITE, 8'd1, 8'h00, 8'h00, 8'h00);
    quantize(8'h00, 8'h00, 8'h01);
    quantize(8'h80, 8'h80, 8'h80);
    send_req(vqncs_pkg::MODE_WRITE, 8'd0, 8'h80, 8'h80, 8'h81);
    send_req(vqncs_pkg::MODE_WRITE, 8'd1, 8'h80, 8'h80, 8'h80);
    quantize(8'h80, 8'h80, 8'h80);
    quantize(8'h80, 8'h80, 8'h82);

    // random phases across small, full and oversized codebooks
    for (int p = 0; p < NUM_PHASES; p++) begin
      run_phase(phase_bits[p], phase_len[p]);
    end

    s_axis_tvalid <= 1'b0;
    while (results_seen != quant_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d pixel searches and %0d codeword writes over %0d size settings,",
             quant_sent, write_sent, NUM_PHASES + 2);
    $display("with ties, distance extremes, sizes 9 and 15 clamped to 8 and a long stall.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
